// ===== hw/rtl/wsfd_pkg.sv =====
package wsfd_pkg;

  localparam int unsigned LENGTH_BITS_DEF = 64;

  localparam logic [3:0] OPC_CLOSE = 4'h8;
  localparam logic [6:0] LEN_EXT16 = 7'd126;
  localparam logic [6:0] LEN_EXT64 = 7'd127;
  localparam logic [2:0] EXT16_BYTES = 3'd2;

  typedef struct packed {
    logic [7:0] payload_byte;
    logic       byte_valid;
    logic [3:0] opcode;
    logic       fin;
    logic       last_in_frame;
    logic       close_seen;
  } res_t;

endpackage

// ===== hw/rtl/wsfd_in_reg.sv =====
module wsfd_in_reg
  import wsfd_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic       take,
  output logic       byte_v,
  output logic [7:0] byte_q
);

  logic       byte_v_r;
  logic       byte_v_nxt;
  logic [7:0] byte_r;
  logic [7:0] byte_nxt;
  logic       load;

  assign in_ready = !byte_v_r || take;
  assign load     = in_valid && in_ready;

  always_comb begin
    byte_v_nxt = byte_v_r;
    byte_nxt   = byte_r;
    if (load) begin
      byte_v_nxt = 1'b1;
      byte_nxt   = in_byte;
    end else if (take) begin
      byte_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_v_r <= 1'b0;
    end else begin
      byte_v_r <= byte_v_nxt;
    end
    byte_r <= byte_nxt;
  end

  assign byte_v = byte_v_r;
  assign byte_q = byte_r;

endmodule

// ===== hw/rtl/wsfd_parser.sv =====
module wsfd_parser
  import wsfd_pkg::*;
#(
  parameter int unsigned LENGTH_BITS = LENGTH_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       byte_v,
  input  logic [7:0] byte_q,
  input  logic       dn_ready,
  output logic       take,
  output logic       res_valid,
  output res_t       res
);

  typedef enum logic [2:0] {
    PH_HDR0,
    PH_HDR1,
    PH_EXT16,
    PH_EXT64,
    PH_KEY,
    PH_DATA
  } phase_t;

  phase_t                 phase_r, phase_nxt;
  logic                   fin_r, fin_nxt;
  logic [3:0]             opc_r, opc_nxt;
  logic                   masked_r, masked_nxt;
  logic [LENGTH_BITS-1:0] rem_r, rem_nxt;
  logic [2:0]             ext_r, ext_nxt;
  logic [31:0]            key_r, key_nxt;
  logic [1:0]             idx_r, idx_nxt;
  logic                   stopped_r, stopped_nxt;
  logic                   hdr_done;
  logic [6:0]             len7;
  logic [7:0]             key_byte;

  assign take     = byte_v && dn_ready;
  assign len7     = byte_q[6:0];
  assign key_byte = key_r[{~idx_r, 3'b000} +: 8];

  always_comb begin
    phase_nxt   = phase_r;
    fin_nxt     = fin_r;
    opc_nxt     = opc_r;
    masked_nxt  = masked_r;
    rem_nxt     = rem_r;
    ext_nxt     = ext_r;
    key_nxt     = key_r;
    idx_nxt     = idx_r;
    stopped_nxt = stopped_r;
    hdr_done    = 1'b0;
    res_valid   = 1'b0;
    res         = '0;
    res.opcode  = opc_r;
    res.fin     = fin_r;
    if (take && !stopped_r) begin
      case (phase_r)
        PH_HDR0: begin
          fin_nxt   = byte_q[7];
          opc_nxt   = byte_q[3:0];
          phase_nxt = PH_HDR1;
        end
        PH_HDR1: begin
          masked_nxt = byte_q[7];
          key_nxt    = '0;
          idx_nxt    = '0;
          ext_nxt    = '0;
          rem_nxt    = '0;
          if (len7 == LEN_EXT16) begin
            phase_nxt = PH_EXT16;
          end else if (len7 == LEN_EXT64) begin
            phase_nxt = PH_EXT64;
          end else begin
            rem_nxt = LENGTH_BITS'(len7);
            if (byte_q[7]) begin
              phase_nxt = PH_KEY;
            end else begin
              hdr_done = 1'b1;
            end
          end
        end
        PH_EXT16, PH_EXT64: begin
          // saturate once the length no longer fits
          if (rem_r[LENGTH_BITS-1 -: 8] != 8'd0) begin
            rem_nxt = '1;
          end else begin
            rem_nxt = {rem_r[LENGTH_BITS-9:0], byte_q};
          end
          ext_nxt = ext_r + 3'd1;
          if ((phase_r == PH_EXT16 && ext_nxt == EXT16_BYTES) ||
              (phase_r == PH_EXT64 && ext_nxt == 3'd0)) begin
            ext_nxt = '0;
            if (masked_r) begin
              phase_nxt = PH_KEY;
            end else begin
              hdr_done = 1'b1;
            end
          end
        end
        PH_KEY: begin
          key_nxt = {key_r[23:0], byte_q};
          idx_nxt = idx_r + 2'd1;
          if (idx_nxt == 2'd0) begin
            hdr_done = 1'b1;
          end
        end
        PH_DATA: begin
          idx_nxt           = idx_r + 2'd1;
          rem_nxt           = rem_r - LENGTH_BITS'(1);
          res_valid         = 1'b1;
          res.payload_byte  = byte_q ^ key_byte;
          res.byte_valid    = 1'b1;
          res.last_in_frame = (rem_nxt == '0);
          if (rem_nxt == '0) begin
            phase_nxt = PH_HDR0;
          end
        end
        default: begin
          phase_nxt = PH_HDR0;
        end
      endcase
      if (hdr_done) begin
        idx_nxt = '0;
        if (opc_r == OPC_CLOSE) begin
          stopped_nxt       = 1'b1;
          res_valid         = 1'b1;
          res.last_in_frame = 1'b1;
          res.close_seen    = 1'b1;
        end else if (rem_nxt == '0) begin
          phase_nxt         = PH_HDR0;
          res_valid         = 1'b1;
          res.last_in_frame = 1'b1;
        end else begin
          phase_nxt = PH_DATA;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_HDR0;
      fin_r     <= 1'b0;
      opc_r     <= '0;
      masked_r  <= 1'b0;
      rem_r     <= '0;
      ext_r     <= '0;
      key_r     <= '0;
      idx_r     <= '0;
      stopped_r <= 1'b0;
    end else begin
      phase_r   <= phase_nxt;
      fin_r     <= fin_nxt;
      opc_r     <= opc_nxt;
      masked_r  <= masked_nxt;
      rem_r     <= rem_nxt;
      ext_r     <= ext_nxt;
      key_r     <= key_nxt;
      idx_r     <= idx_nxt;
      stopped_r <= stopped_nxt;
    end
  end

  a_stop_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    stopped_r |=> stopped_r)
    else $error("stop flag cleared without reset");

  a_no_res_after_close: assert property (@(posedge clk) disable iff (!rst_n)
    stopped_r |-> !res_valid)
    else $error("result produced after close");

  a_close_shape: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && res.close_seen) |-> (res.last_in_frame && !res.byte_valid
                                        && opc_r == OPC_CLOSE))
    else $error("malformed close report");

  a_empty_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && !res.byte_valid) |-> res.last_in_frame)
    else $error("empty result not marked last");

endmodule

// ===== hw/rtl/wsfd_out_skid.sv =====
module wsfd_out_skid
  import wsfd_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic up_valid,
  output logic up_ready,
  input  res_t up_res,
  output logic out_valid,
  input  logic out_ready,
  output res_t out_res
);

  logic main_v_r, main_v_nxt;
  res_t main_r, main_nxt;
  logic skid_v_r, skid_v_nxt;
  res_t skid_r, skid_nxt;
  logic push;

  assign up_ready = !skid_v_r;
  assign push     = up_valid && up_ready;

  always_comb begin
    main_v_nxt = main_v_r;
    main_nxt   = main_r;
    skid_v_nxt = skid_v_r;
    skid_nxt   = skid_r;
    if (!main_v_r || out_ready) begin
      if (skid_v_r) begin
        main_v_nxt = 1'b1;
        main_nxt   = skid_r;
        skid_v_nxt = 1'b0;
      end else if (push) begin
        main_v_nxt = 1'b1;
        main_nxt   = up_res;
      end else begin
        main_v_nxt = 1'b0;
      end
    end else if (push) begin
      skid_v_nxt = 1'b1;
      skid_nxt   = up_res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_v_r <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      main_v_r <= main_v_nxt;
      skid_v_r <= skid_v_nxt;
    end
    main_r <= main_nxt;
    skid_r <= skid_nxt;
  end

  assign out_valid = main_v_r;
  assign out_res   = main_r;

  a_skid_behind_main: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r |-> main_v_r)
    else $error("skid entry without head entry");

endmodule

// ===== hw/rtl/websocket_frame_decoder_top.sv =====
// channel  | handshake             | payload
// ---------+-----------------------+---------------------------------------------
// in       | in_valid / in_ready   | in_byte
// out      | out_valid / out_ready | out_payload_byte, out_byte_valid, out_opcode,
//          |                       | out_fin, out_last_in_frame, out_close_seen
//
// one byte accepted per cycle unless out stalls; bytes after a close give no result
// byte register -> header/payload decode -> two-entry result register
// header bytes give no request on out but the last of an empty or close frame
// in_ready depends on registers only; stalls on out back up through the skid entry
// synchronous active-low reset returns to the first header byte and clears the stop
module websocket_frame_decoder_top
  import wsfd_pkg::*;
#(
  parameter int unsigned LENGTH_BITS = LENGTH_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_payload_byte,
  output logic       out_byte_valid,
  output logic [3:0] out_opcode,
  output logic       out_fin,
  output logic       out_last_in_frame,
  output logic       out_close_seen
);

  logic       take;
  logic       byte_v;
  logic [7:0] byte_q;
  logic       dn_ready;
  logic       res_valid;
  res_t       res;
  res_t       out_res;

  wsfd_in_reg u_in_reg (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_byte  (in_byte),
    .take     (take),
    .byte_v   (byte_v),
    .byte_q   (byte_q)
  );

  wsfd_parser #(
    .LENGTH_BITS (LENGTH_BITS)
  ) u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .byte_v    (byte_v),
    .byte_q    (byte_q),
    .dn_ready  (dn_ready),
    .take      (take),
    .res_valid (res_valid),
    .res       (res)
  );

  wsfd_out_skid u_out_skid (
    .clk       (clk),
    .rst_n     (rst_n),
    .up_valid  (res_valid),
    .up_ready  (dn_ready),
    .up_res    (res),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (out_res)
  );

  assign out_payload_byte  = out_res.payload_byte;
  assign out_byte_valid    = out_res.byte_valid;
  assign out_opcode        = out_res.opcode;
  assign out_fin           = out_res.fin;
  assign out_last_in_frame = out_res.last_in_frame;
  assign out_close_seen    = out_res.close_seen;

endmodule

// ===== sim/websocket_frame_decoder_checker.sv =====
module websocket_frame_decoder_checker
  import wsfd_pkg::*;
#(
  parameter int unsigned LENGTH_BITS = LENGTH_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic       out_valid,
  input  logic       out_ready,
  input  logic [7:0] out_payload_byte,
  input  logic       out_byte_valid,
  input  logic [3:0] out_opcode,
  input  logic       out_fin,
  input  logic       out_last_in_frame,
  input  logic       out_close_seen,
  output int         mismatches,
  output int         outstanding
);

  typedef enum logic [2:0] {
    PH_FIRST,
    PH_SECOND,
    PH_LEN16,
    PH_LEN64,
    PH_KEY,
    PH_DATA
  } phase_t;

  localparam logic [63:0] LEN_MAX = {64{1'b1}} >> (64 - LENGTH_BITS);

  phase_t      phase;
  logic        hdr_fin;
  logic [3:0]  hdr_opcode;
  logic        hdr_masked;
  logic [63:0] bytes_left;
  logic [2:0]  len_bytes_seen;
  logic [31:0] mask_word;
  logic [1:0]  key_pos;
  logic        stopped;
  res_t        due_results[$];

  task automatic post_result(input logic [7:0] data, input logic valid, input logic last,
                             input logic cls);
    res_t r;
    r.payload_byte  = data;
    r.byte_valid    = valid;
    r.opcode        = hdr_opcode;
    r.fin           = hdr_fin;
    r.last_in_frame = last;
    r.close_seen    = cls;
    due_results.insert(due_results.size(), r);
  endtask

  task automatic end_header();
    key_pos = '0;
    if (hdr_opcode == OPC_CLOSE) begin
      stopped = 1'b1;
      post_result(8'h00, 1'b0, 1'b1, 1'b1);
    end else if (bytes_left == '0) begin
      phase = PH_FIRST;
      post_result(8'h00, 1'b0, 1'b1, 1'b0);
    end else begin
      phase = PH_DATA;
    end
  endtask

  task automatic deframe_byte(input logic [7:0] b);
    logic [7:0] pad;
    if (!stopped) begin
      case (phase)
        PH_FIRST: begin
          hdr_fin    = b[7];
          hdr_opcode = b[3:0];
          phase      = PH_SECOND;
        end
        PH_SECOND: begin
          hdr_masked     = b[7];
          mask_word      = '0;
          key_pos        = '0;
          len_bytes_seen = '0;
          bytes_left     = '0;
          if (b[6:0] == LEN_EXT16) begin
            phase = PH_LEN16;
          end else if (b[6:0] == LEN_EXT64) begin
            phase = PH_LEN64;
          end else begin
            bytes_left = 64'(b[6:0]);
            if (hdr_masked) begin
              phase = PH_KEY;
            end else begin
              end_header();
            end
          end
        end
        PH_LEN16, PH_LEN64: begin
          // saturate rather than lose high bits
          if (bytes_left > (LEN_MAX >> 8)) begin
            bytes_left = LEN_MAX;
          end else begin
            bytes_left = (bytes_left << 8) | 64'(b);
            if (bytes_left > LEN_MAX) bytes_left = LEN_MAX;
          end
          len_bytes_seen = len_bytes_seen + 3'd1;
          if ((phase == PH_LEN16 && len_bytes_seen == EXT16_BYTES) ||
              (phase == PH_LEN64 && len_bytes_seen == 3'd0)) begin
            len_bytes_seen = '0;
            if (hdr_masked) begin
              phase = PH_KEY;
            end else begin
              end_header();
            end
          end
        end
        PH_KEY: begin
          mask_word = {mask_word[23:0], b};
          key_pos   = key_pos + 2'd1;
          if (key_pos == 2'd0) end_header();
        end
        PH_DATA: begin
          pad        = mask_word[31 - 8 * key_pos -: 8];
          key_pos    = key_pos + 2'd1;
          bytes_left = bytes_left - 64'd1;
          if (bytes_left == '0) phase = PH_FIRST;
          post_result(b ^ pad, 1'b1, bytes_left == '0, 1'b0);
        end
        default: phase = PH_FIRST;
      endcase
    end
  endtask

  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (got !== want) begin
      $error("%s expected 0x%0h got 0x%0h", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin : track
    res_t want;
    if (!rst_n) begin
      phase          = PH_FIRST;
      hdr_fin        = 1'b0;
      hdr_opcode     = '0;
      hdr_masked     = 1'b0;
      bytes_left     = '0;
      len_bytes_seen = '0;
      mask_word      = '0;
      key_pos        = '0;
      stopped        = 1'b0;
      mismatches     = 0;
      due_results.delete();
    end else begin
      if (in_valid && in_ready) deframe_byte(in_byte);
      if (out_valid && out_ready) begin
        if (due_results.size() == 0) begin
          $error("request on out with nothing expected: payload_byte 0x%0h", out_payload_byte);
          mismatches++;
        end else begin
          want = due_results.pop_front();
          check_field("payload_byte", want.payload_byte, out_payload_byte);
          check_field("byte_valid", 8'(want.byte_valid), 8'(out_byte_valid));
          check_field("opcode", 8'(want.opcode), 8'(out_opcode));
          check_field("fin", 8'(want.fin), 8'(out_fin));
          check_field("last_in_frame", 8'(want.last_in_frame), 8'(out_last_in_frame));
          check_field("close_seen", 8'(want.close_seen), 8'(out_close_seen));
        end
      end
    end
    outstanding <= due_results.size();
  end

endmodule

// ===== sim/websocket_frame_decoder_top_test.sv =====
module websocket_frame_decoder_top_test;
  import wsfd_pkg::*;

  localparam int ITEMS       = 1650;
  localparam int STALL_LIMIT = 1000;

  typedef enum int {
    FORM_SHORT,
    FORM_EXT16,
    FORM_EXT64
  } len_form_t;

  typedef enum int {
    FILL_RANDOM,
    FILL_ZERO,
    FILL_ONES
  } fill_t;

  logic       clk = 1'b0;
  logic       rst_n;
  logic       in_valid;
  logic       in_ready;
  logic [7:0] in_byte;
  logic       out_valid;
  logic       out_ready;
  logic [7:0] out_payload_byte;
  logic       out_byte_valid;
  logic [3:0] out_opcode;
  logic       out_fin;
  logic       out_last_in_frame;
  logic       out_close_seen;

  int mismatches;
  int outstanding;
  int idle_cycles;
  int bytes_sent;
  bit in_steady;
  bit out_steady;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  websocket_frame_decoder_top i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_byte           (in_byte),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_payload_byte  (out_payload_byte),
    .out_byte_valid    (out_byte_valid),
    .out_opcode        (out_opcode),
    .out_fin           (out_fin),
    .out_last_in_frame (out_last_in_frame),
    .out_close_seen    (out_close_seen)
  );

  websocket_frame_decoder_checker i_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_byte           (in_byte),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_payload_byte  (out_payload_byte),
    .out_byte_valid    (out_byte_valid),
    .out_opcode        (out_opcode),
    .out_fin           (out_fin),
    .out_last_in_frame (out_last_in_frame),
    .out_close_seen    (out_close_seen),
    .mismatches        (mismatches),
    .outstanding       (outstanding)
  );

  function automatic int draw_wait(input bit steady);
    return steady ? 0 : $urandom_range(0, 11);
  endfunction

  task automatic push_byte(input logic [7:0] b);
    int gap;
    if ($urandom_range(0, 39) == 0) in_steady = !in_steady;
    gap = draw_wait(in_steady);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_byte  <= b;
    do @(posedge clk); while (!in_ready);
    bytes_sent++;
  endtask

  task automatic send_frame(input logic [3:0] opcode, input logic fin, input logic [2:0] rsv,
                            input logic masked, input logic [31:0] key_bytes,
                            input len_form_t form, input logic [63:0] length,
                            input fill_t fill);
    logic [63:0] n;
    logic [7:0]  data;
    push_byte({fin, rsv, opcode});
    case (form)
      FORM_SHORT: push_byte({masked, length[6:0]});
      FORM_EXT16: begin
        push_byte({masked, LEN_EXT16});
        push_byte(length[15:8]);
        push_byte(length[7:0]);
      end
      default: begin
        push_byte({masked, LEN_EXT64});
        for (int i = 7; i >= 0; i--) push_byte(length[8 * i +: 8]);
      end
    endcase
    if (masked) begin
      for (int i = 3; i >= 0; i--) push_byte(key_bytes[8 * i +: 8]);
    end
    // a close frame stops the block at its header, so no payload follows
    if (opcode != OPC_CLOSE) begin
      for (n = 0; n < length; n++) begin
        case (fill)
          FILL_ZERO: data = 8'h00;
          FILL_ONES: data = 8'hFF;
          default:   data = 8'($urandom_range(0, 255));
        endcase
        push_byte(data);
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      idle_cycles <= 0;
    end else if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == STALL_LIMIT) begin
      $display("status: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int gap;
    out_ready  <= 1'b0;
    out_steady  = 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if ($urandom_range(0, 39) == 0) out_steady = !out_steady;
      gap = draw_wait(out_steady);
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  initial begin
    logic [3:0]  opcode;
    logic [63:0] length;
    len_form_t   form;
    int          pick;
    rst_n      <= 1'b0;
    in_valid   <= 1'b0;
    in_byte    <= '0;
    bytes_sent  = 0;
    in_steady   = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty frames, all-ones key with rsv set, 64-bit length form
    send_frame(4'h1, 1'b1, 3'b000, 1'b0, 32'h0, FORM_SHORT, 64'd0, FILL_RANDOM);
    send_frame(4'hA, 1'b1, 3'b000, 1'b0, 32'h0, FORM_EXT16, 64'd0, FILL_RANDOM);
    send_frame(4'h0, 1'b0, 3'b111, 1'b1, 32'hFFFF_FFFF, FORM_SHORT, 64'd2, FILL_ONES);
    send_frame(4'hF, 1'b1, 3'b000, 1'b0, 32'h0, FORM_EXT64, 64'd1, FILL_ZERO);

    while (bytes_sent < ITEMS) begin
      do opcode = 4'($urandom_range(0, 15)); while (opcode == OPC_CLOSE);
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        form   = FORM_SHORT;
        length = ($urandom_range(0, 9) == 0) ? 64'($urandom_range(100, 125))
                                             : 64'($urandom_range(0, 12));
      end else if (pick < 85) begin
        form   = FORM_EXT16;
        length = ($urandom_range(0, 3) == 0) ? 64'($urandom_range(126, 300))
                                             : 64'($urandom_range(0, 20));
      end else begin
        form   = FORM_EXT64;
        length = 64'($urandom_range(0, 40));
      end
      send_frame(opcode, 1'($urandom_range(0, 1)), 3'($urandom_range(0, 7)),
                 1'($urandom_range(0, 1)), $urandom(), form, length, FILL_RANDOM);
    end

    // close ends the stream; everything after it must be dropped
    send_frame(OPC_CLOSE, 1'($urandom_range(0, 1)), 3'($urandom_range(0, 7)),
               1'($urandom_range(0, 1)), $urandom(), len_form_t'($urandom_range(0, 2)),
               64'($urandom_range(0, 125)), FILL_RANDOM);
    push_byte({1'b1, 3'b000, OPC_CLOSE});
    repeat (7) push_byte(8'($urandom_range(0, 255)));
    in_valid <= 1'b0;

    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (16) @(posedge clk);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
